// ===== src/nta_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nta_pkg: shared types and constants of the number to ASCII formatter
// Holds the port payload types, the per-cell conversion record, the format
// codes and the ASCII constants used by the conversion chain and emitter.
// ---------------------------------------------------------------------------
package nta_pkg;

  localparam int BIN_W          = 32;
  localparam int FRAC_W         = 10;
  localparam int BCD_DIGITS     = 10;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int FRAC_DIGITS    = 3;
  localparam int FBCD_W         = 4 * FRAC_DIGITS;
  localparam int DEC_DIGITS_DEF = 7;
  localparam int MAX_CHARS_DEF  = 16;

  localparam logic [1:0] FN_DEC  = 2'd0;
  localparam logic [1:0] FN_FRAC = 2'd1;
  localparam logic [1:0] FN_HEX  = 2'd2;
  localparam logic [1:0] FN_NONE = 2'd3;

  localparam logic [7:0]        ASCII_ZERO      = 8'h30;
  localparam logic [7:0]        ASCII_HEX_ALPHA = 8'h37;
  localparam logic [7:0]        ASCII_COMMA     = 8'h2C;
  localparam logic [7:0]        ASCII_X         = 8'h78;
  localparam logic [FRAC_W-1:0] FRAC_MAX        = 10'd999;

  typedef struct packed {
    logic [1:0]        func;
    logic [BIN_W-1:0]  int_val;
    logic [FRAC_W-1:0] frac_milli;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // One slot of the conversion chain.
  typedef struct packed {
    logic              vld;
    logic              hex;
    logic              frac_en;
    logic [BIN_W-1:0]  bin;
    logic [BIN_W-1:0]  fbin;
    logic [BCD_W-1:0]  bcd;
    logic [FBCD_W-1:0] fbcd;
  } nta_cell_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== src/nta_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nta_cell: one shift-and-correct step of the binary to BCD chain
// Applies the add-three correction to every BCD digit that is five or more,
// then shifts the next binary bit in. In hex mode the correction of the integer
// digits is skipped, so their register collects the plain binary nibbles.
// ---------------------------------------------------------------------------
module nta_cell
  import nta_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire nta_cell_t d_in,
  output nta_cell_t      d_out
);

  nta_cell_t         cell_r;
  nta_cell_t         cell_nxt;
  logic [BCD_W-1:0]  bcd_c;
  logic [FBCD_W-1:0] fbcd_c;

  always_comb begin
    bcd_c  = d_in.bcd;
    fbcd_c = d_in.fbcd;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (!d_in.hex && bcd_c[4*k +: 4] >= 4'd5) begin
        bcd_c[4*k +: 4] = bcd_c[4*k +: 4] + 4'd3;
      end
    end
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (fbcd_c[4*k +: 4] >= 4'd5) begin
        fbcd_c[4*k +: 4] = fbcd_c[4*k +: 4] + 4'd3;
      end
    end
    cell_nxt         = d_in;
    cell_nxt.bcd     = {bcd_c[BCD_W-2:0], d_in.bin[BIN_W-1]};
    cell_nxt.fbcd    = {fbcd_c[FBCD_W-2:0], d_in.fbin[BIN_W-1]};
    cell_nxt.bin     = {d_in.bin[BIN_W-2:0], 1'b0};
    cell_nxt.fbin    = {d_in.fbin[BIN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

// ===== src/nta_emit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nta_emit: character sequencer and output register
// Takes a converted number from the end of the chain, suppresses leading
// zeros and sends one ASCII character per transfer, flagging the final one.
// ---------------------------------------------------------------------------
module nta_emit
  import nta_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire nta_cell_t ld,
  output logic           ld_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_t           out_data
);

  localparam int CNT_W = $clog2(MAX_CHARS);
  localparam int IDX_W = $clog2(BCD_DIGITS);
  localparam int FID_W = $clog2(FRAC_DIGITS);

  localparam logic [2:0] PH_P0    = 3'd0;
  localparam logic [2:0] PH_PX    = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_COMMA = 3'd3;
  localparam logic [2:0] PH_FRAC  = 3'd4;

  logic              busy_r, busy_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FID_W-1:0]  fidx_r, fidx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BCD_W-1:0]  dig_r, dig_nxt;
  logic [FBCD_W-1:0] fdig_r, fdig_nxt;
  logic              frac_en_r, frac_en_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic             emit;
  logic             fin;
  logic             last;
  logic [3:0]       d;
  logic [7:0]       ch;
  logic [IDX_W-1:0] ilead;
  logic [FID_W-1:0] flead;

  // Position of the most significant nonzero digit; zero prints one digit.
  always_comb begin
    ilead = '0;
    flead = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (ld.bcd[4*k +: 4] != 4'd0) begin
        ilead = IDX_W'(k);
      end
    end
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (ld.fbcd[4*k +: 4] != 4'd0) begin
        flead = FID_W'(k);
      end
    end
  end

  always_comb begin
    ch  = ASCII_ZERO;
    fin = 1'b0;
    d   = 4'd0;
    case (phase_r)
      PH_P0: begin
        ch = ASCII_ZERO;
      end
      PH_PX: begin
        ch = ASCII_X;
      end
      PH_INT: begin
        d   = dig_r[4*idx_r +: 4];
        ch  = (d < 4'd10) ? ASCII_ZERO + {4'd0, d} : ASCII_HEX_ALPHA + {4'd0, d};
        fin = (idx_r == '0) && !frac_en_r;
      end
      PH_COMMA: begin
        ch = ASCII_COMMA;
      end
      PH_FRAC: begin
        d   = fdig_r[4*fidx_r +: 4];
        ch  = ASCII_ZERO + {4'd0, d};
        fin = (fidx_r == '0);
      end
      default: begin
        ch  = ASCII_ZERO;
        fin = 1'b1;
      end
    endcase
  end

  assign emit    = busy_r && (!out_valid_r || out_ready);
  assign last    = fin || (cnt_r == CNT_W'(MAX_CHARS - 1));
  // A new number loads while idle, or in the same cycle as the final character is registered for output.
  assign ld_take = ld.vld && (!busy_r || (emit && last));

  always_comb begin
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    fidx_nxt      = fidx_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    fdig_nxt      = fdig_r;
    frac_en_nxt   = frac_en_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.char_code = ch;
      out_data_nxt.last      = last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ld_take) begin
      busy_nxt    = 1'b1;
      phase_nxt   = ld.hex ? PH_P0 : PH_INT;
      idx_nxt     = ilead;
      fidx_nxt    = flead;
      cnt_nxt     = '0;
      dig_nxt     = ld.bcd;
      fdig_nxt    = ld.fbcd;
      frac_en_nxt = ld.frac_en;
    end else if (emit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
      case (phase_r)
        PH_P0: begin
          phase_nxt = PH_PX;
        end
        PH_PX: begin
          phase_nxt = PH_INT;
        end
        PH_INT: begin
          if (idx_r == '0) begin
            phase_nxt = PH_COMMA;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
        PH_COMMA: begin
          phase_nxt = PH_FRAC;
        end
        PH_FRAC: begin
          fidx_nxt = fidx_r - FID_W'(1);
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_INT;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    fidx_r     <= fidx_nxt;
    cnt_r      <= cnt_nxt;
    dig_r      <= dig_nxt;
    fdig_r     <= fdig_nxt;
    frac_en_r  <= frac_en_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_frac_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (phase_r == PH_FRAC || phase_r == PH_COMMA)) |-> frac_en_r)
    else $error("fraction phase reached without fraction format");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= CNT_W'(MAX_CHARS - 1)))
    else $error("character count exceeds the cap");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r == PH_INT) |-> (idx_r < IDX_W'(BCD_DIGITS)))
    else $error("digit index out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld_take |=> (busy_r && cnt_r == '0))
    else $error("load did not start a fresh number");

endmodule
`default_nettype wire

// ===== src/number_to_ascii_formatter.sv =====
`default_nettype none
// An input transfer reaches out_valid through the cell chain, the emitter's digit registers and its output register.
// The 32-cell conversion chain takes one number per cycle while it can move.
// The output gives one character per cycle while out_ready is high, and a number
// has 1 to 11 characters, at most MAX_CHARS.
// Reset (rst_n low at a clock edge) empties the chain and the output register.
// ---------------------------------------------------------------------------
// number_to_ascii_formatter: number to ASCII character stream
// Clamps and loads a number into a chain of binary to BCD cells, then emits
// its decimal, integer comma fraction or hex text one character at a time.
// ---------------------------------------------------------------------------
module number_to_ascii_formatter
  import nta_pkg::*;
#(
  parameter int DEC_DIGITS = DEC_DIGITS_DEF,
  parameter int MAX_CHARS  = MAX_CHARS_DEF
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam logic [63:0] DEC_LIM = pow10(DEC_DIGITS) - 64'd1;

  nta_cell_t         chain [BIN_W+1];
  logic              adv;
  logic              ld_take;
  logic [BIN_W-1:0]  ival;
  logic [FRAC_W-1:0] fval;

  always_comb begin
    ival = in_data.int_val;
    if (in_data.func != FN_HEX &&
        {{(64-BIN_W){1'b0}}, in_data.int_val} > DEC_LIM) begin
      ival = DEC_LIM[BIN_W-1:0];
    end
    fval = (in_data.frac_milli > FRAC_MAX) ? FRAC_MAX : in_data.frac_milli;
  end

  // The unused format code is taken and dropped here.
  assign chain[0] = '{
    vld:     in_valid && (in_data.func != FN_NONE),
    hex:     (in_data.func == FN_HEX),
    frac_en: (in_data.func == FN_FRAC),
    bin:     ival,
    fbin:    {{(BIN_W-FRAC_W){1'b0}}, fval},
    bcd:     '0,
    fbcd:    '0
  };

  // The whole chain moves together when its end is empty or being drained.
  assign adv      = !chain[BIN_W].vld || ld_take;
  assign in_ready = adv;

  for (genvar i = 0; i < BIN_W; i++) begin : g_cell
    nta_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  nta_emit #(
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (chain[BIN_W]),
    .ld_take   (ld_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== bench/tb_number_to_ascii_formatter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_number_to_ascii_formatter: character stream check of the ASCII formatter
// Drives numbers in all three formats and the unused code through the
// valid/ready input, predicts the text of each one and compares every
// character and its last flag as it leaves, with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_number_to_ascii_formatter;
  import nta_pkg::*;

  localparam int SAT_DIGITS   = DEC_DIGITS_DEF;
  localparam int CHAR_CAP     = MAX_CHARS_DEF;
  localparam int RANDOM_ITEMS = 245;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 300000;

  typedef out_t char_q_t[$];
  typedef logic [7:0] text_t[$];

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  out_t   pending_text[$];
  int     errors = 0;
  int     cycles = 0;
  int     numbers_sent = 0;
  int     chars_checked = 0;
  int     per_format[4] = '{0, 0, 0, 0};
  int     saturated = 0;
  int     frac_clamped = 0;

  in_t    dir_items[$];
  bit     dir_typed[$];
  string  dir_text[$];

  number_to_ascii_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_number_to_ascii_formatter: errors");
      $finish;
    end
  end

  function automatic logic [63:0] decimal_ceiling();
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < SAT_DIGITS; k++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

  function automatic void put_decimal(ref text_t t, input logic [63:0] v);
    text_t digits;
    do begin
      digits.push_front(ASCII_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digits[k]) t.push_back(digits[k]);
  endfunction

  // Expected character stream of one number, cut at the length cap.
  function automatic char_q_t render_number(input in_t item);
    text_t       txt;
    char_q_t     chars;
    logic [63:0] ceiling;
    logic [63:0] whole;
    logic [9:0]  frac;
    logic [3:0]  nib;
    bit          seen;
    int          n;
    ceiling = decimal_ceiling();
    whole   = ({32'd0, item.int_val} > ceiling) ? ceiling : {32'd0, item.int_val};
    frac    = (item.frac_milli > FRAC_MAX) ? FRAC_MAX : item.frac_milli;
    seen    = 1'b0;
    case (item.func)
      FN_DEC: begin
        put_decimal(txt, whole);
      end
      FN_FRAC: begin
        put_decimal(txt, whole);
        txt.push_back(ASCII_COMMA);
        put_decimal(txt, {54'd0, frac});
      end
      FN_HEX: begin
        txt.push_back(ASCII_ZERO);
        txt.push_back(ASCII_X);
        for (int k = 7; k >= 0; k--) begin
          nib = item.int_val[4*k +: 4];
          if (nib != 4'd0) seen = 1'b1;
          if (seen || k == 0) begin
            txt.push_back(nib < 4'd10 ? ASCII_ZERO + 8'(nib) : ASCII_HEX_ALPHA + 8'(nib));
          end
        end
      end
      default: begin
      end
    endcase
    n = (txt.size() > CHAR_CAP) ? CHAR_CAP : txt.size();
    for (int k = 0; k < n; k++) begin
      chars.push_back('{char_code: txt[k], last: (k == n - 1)});
    end
    return chars;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [31:0] whole,
                         input logic [9:0] frac, input bit typed, input string text);
    dir_items.push_back('{func: func, int_val: whole, frac_milli: frac});
    dir_typed.push_back(typed);
    dir_text.push_back(text);
  endtask

  // Holds one number on the input until its transfer, then records its text.
  task automatic send_number(input in_t item, input bit typed, input string text);
    int      gap;
    char_q_t chars;
    gap = (numbers_sent % 64 < 16) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      for (int k = 0; k < text.len(); k++) begin
        chars.push_back('{char_code: text[k], last: (k == text.len() - 1)});
      end
    end else begin
      chars = render_number(item);
    end
    foreach (chars[k]) pending_text.push_back(chars[k]);
    numbers_sent++;
    per_format[item.func]++;
    if (item.func inside {FN_DEC, FN_FRAC} && {32'd0, item.int_val} > decimal_ceiling())
      saturated++;
    if (item.func == FN_FRAC && item.frac_milli > FRAC_MAX) frac_clamped++;
  endtask

  function automatic in_t random_number();
    in_t item;
    int  pick;
    pick = $urandom_range(0, 99);
    item.func = (pick < 5) ? FN_NONE : (pick < 37) ? FN_DEC : (pick < 69) ? FN_FRAC : FN_HEX;
    case ($urandom_range(0, 4))
      0: item.int_val = $urandom();
      1: item.int_val = $urandom_range(0, 15);
      2: item.int_val = $urandom_range(9999990, 10000010);
      3: item.int_val = $urandom() >> $urandom_range(0, 31);
      default: item.int_val = $urandom_range(0, 9999999);
    endcase
    item.frac_milli = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
                                                  : 10'($urandom_range(0, 999));
    return item;
  endfunction

  always @(posedge clk) begin : check_chars
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_checked++;
      if (pending_text.size() == 0) begin
        $error("unexpected character: char_code 0x%02h last %0b",
               out_data.char_code, out_data.last);
        errors++;
      end else begin
        want = pending_text.pop_front();
        if (out_data.char_code !== want.char_code) begin
          $error("char_code: expected 0x%02h, got 0x%02h", want.char_code, out_data.char_code);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Result side: a random stall before each character, with stall-free stretches.
  initial begin : drain_side
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = (chars_checked % 100 < 25) ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stimulus
    int useful;
    in_t item;

    add_row(FN_DEC,  32'd0,          10'd0,    1'b1, "0");
    add_row(FN_DEC,  32'd1,          10'd0,    1'b1, "1");
    add_row(FN_DEC,  32'd9999999,    10'd0,    1'b1, "9999999");
    add_row(FN_DEC,  32'd10000000,   10'd0,    1'b1, "9999999");
    add_row(FN_DEC,  32'hFFFF_FFFF,  10'h3FF,  1'b1, "9999999");
    add_row(FN_DEC,  32'd1000000,    10'd0,    1'b0, "");
    add_row(FN_DEC,  32'd1234567,    10'h155,  1'b0, "");
    add_row(FN_FRAC, 32'd0,          10'd0,    1'b1, "0,0");
    add_row(FN_FRAC, 32'hFFFF_FFFF,  10'h3FF,  1'b1, "9999999,999");
    add_row(FN_FRAC, 32'd0,          10'd1000, 1'b1, "0,999");
    add_row(FN_FRAC, 32'd12,         10'd5,    1'b0, "");
    add_row(FN_FRAC, 32'd3,          10'd999,  1'b0, "");
    add_row(FN_FRAC, 32'h5555_5555,  10'h2AA,  1'b0, "");
    add_row(FN_FRAC, 32'd9999999,    10'd100,  1'b0, "");
    add_row(FN_HEX,  32'd0,          10'd0,    1'b1, "0x0");
    add_row(FN_HEX,  32'hFFFF_FFFF,  10'h3FF,  1'b1, "0xFFFFFFFF");
    add_row(FN_HEX,  32'h0000_000A,  10'd0,    1'b1, "0xA");
    add_row(FN_HEX,  32'h1000_0000,  10'd0,    1'b0, "");
    add_row(FN_HEX,  32'h89AB_CDEF,  10'd0,    1'b0, "");
    add_row(FN_HEX,  32'h0123_4567,  10'h155,  1'b0, "");
    add_row(FN_NONE, 32'hFFFF_FFFF,  10'h3FF,  1'b1, "");
    add_row(FN_NONE, 32'd0,          10'd0,    1'b1, "");
    add_row(FN_DEC,  32'hAAAA_AAAA,  10'h2AA,  1'b0, "");

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_items[i]) send_number(dir_items[i], dir_typed[i], dir_text[i]);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      item = random_number();
      send_number(item, 1'b0, "");
      if (item.func != FN_NONE) useful++;
      // Once midway, let the block run completely dry before going on.
      if (useful == RANDOM_ITEMS / 2 && item.func != FN_NONE) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_text.size() != 0);
      end
    end
    in_valid <= 1'b0;

    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d numbers: %0d decimal, %0d with fraction, %0d hex, %0d unused code.",
             numbers_sent, per_format[FN_DEC], per_format[FN_FRAC], per_format[FN_HEX],
             per_format[FN_NONE]);
    $display("Checked %0d characters; %0d saturated values, %0d clamped fractions.",
             chars_checked, saturated, frac_clamped);
    if (errors == 0) begin
      $display("tb_number_to_ascii_formatter: clean");
    end else begin
      $display("tb_number_to_ascii_formatter: errors");
    end
    $finish;
  end

endmodule
